// ----- design/pida_pkg.sv -----
// ----------------------------------------------------------------------------
// pida_pkg
// Shared types and constants for the positional insert/delete array.
// ----------------------------------------------------------------------------
package pida_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned ST_W      = 2;
  localparam int unsigned EPOS_W    = 6;
  localparam int unsigned LEN_W     = 7;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_READ   = 3'd1,
    OP_INSERT = 3'd2,
    OP_UPDATE = 3'd3,
    OP_DELETE = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_RUN   = 2'd1,
    S_DRAIN = 2'd2,
    S_FINAL = 2'd3
  } state_e;

  typedef enum logic [1:0] {
    M_READ = 2'd0,
    M_UP   = 2'd1,
    M_DN   = 2'd2
  } mode_e;

endpackage

// ----- design/positional_insert_delete_array_core.sv -----
// ----------------------------------------------------------------------------
// positional_insert_delete_array_core
// Packed array of signed words with a live length; clear, read all, insert,
// update and delete operations on a single-port-write, registered-read RAM.
// Clear, update, errors, insert at the end and delete of the last entry: the
// result beat comes in the cycle after start, and the next start is taken at once.
// Insert at p: busy while entries p and up move up, one RAM move per cycle; result follows.
// Delete at p: busy while entries above p move down; read all: one beat a cycle.
// Results cannot be stalled. Reset empties the array; RAM contents stay as is.
// ----------------------------------------------------------------------------
module positional_insert_delete_array_core
  import pida_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [VAL_W-1:0]  value_i,
  output logic              valid_o,
  output logic [ST_W-1:0]   status_o,
  output logic [VAL_W-1:0]  element_o,
  output logic [EPOS_W-1:0] element_position_o,
  output logic [LEN_W-1:0]  length_now_o,
  output logic              last_o
);

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  pida_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start),
    .busy_o             (busy),
    .operation_i        (operation_i),
    .position_i         (position_i),
    .value_i            (value_i),
    .valid_o            (valid_o),
    .status_o           (status_o),
    .element_o          (element_o),
    .element_position_o (element_position_o),
    .length_now_o       (length_now_o),
    .last_o             (last_o),
    .ram_we_o           (ram_we),
    .ram_waddr_o        (ram_waddr),
    .ram_wdata_o        (ram_wdata),
    .ram_re_o           (ram_re),
    .ram_raddr_o        (ram_raddr),
    .ram_rdata_i        (ram_rdata)
  );

  pida_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ----- design/pida_ram.sv -----
// ----------------------------------------------------------------------------
// pida_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pida_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/pida_ctrl.sv -----
// ----------------------------------------------------------------------------
// pida_ctrl
// Sequencer: decodes operations, checks bounds, walks the RAM to shift or
// read out entries and drives the result registers.
// ----------------------------------------------------------------------------
module pida_ctrl
  import pida_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned LW = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [VAL_W-1:0]  value_i,
  output logic              valid_o,
  output logic [ST_W-1:0]   status_o,
  output logic [VAL_W-1:0]  element_o,
  output logic [EPOS_W-1:0] element_position_o,
  output logic [LEN_W-1:0]  length_now_o,
  output logic              last_o,
  output logic              ram_we_o,
  output logic [AW-1:0]     ram_waddr_o,
  output logic [VAL_W-1:0]  ram_wdata_o,
  output logic              ram_re_o,
  output logic [AW-1:0]     ram_raddr_o,
  input  logic [VAL_W-1:0]  ram_rdata_i
);

  state_e            state_q, state_d;
  mode_e             mode_q, mode_d;
  logic [LW-1:0]     len_q, len_d;
  logic [AW-1:0]     cursor_q, cursor_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [VAL_W-1:0]  val_q, val_d;
  logic              rd_vld_q, rd_vld_d;
  logic [AW-1:0]     rd_addr_q, rd_addr_d;

  logic              out_vld_q, out_vld_d;
  status_e           out_st_q, out_st_d;
  logic [VAL_W-1:0]  out_elem_q, out_elem_d;
  logic [EPOS_W-1:0] out_epos_q, out_epos_d;
  logic [LEN_W-1:0]  out_len_q, out_len_d;
  logic              out_last_q, out_last_d;

  logic              accept;
  logic [AW-1:0]     last_idx;
  logic [LEN_W-1:0]  len_ext;
  logic [AW-1:0]     pos_a;
  logic              run_done;
  logic              start_run;
  logic              to_idle;

  assign busy_o   = (state_q != S_IDLE);
  assign accept   = start_i && !busy_o;
  assign last_idx = AW'(len_q - LW'(1));
  assign len_ext  = LEN_W'(len_q);
  assign pos_a    = position_i[AW-1:0];
  assign run_done = (mode_q == M_UP) ? (cursor_q == pos_q) : (cursor_q == last_idx);

  // decides whether an accepted operation needs a RAM walk
  always_comb begin
    start_run = 1'b0;
    if (accept) begin
      case (op_e'(operation_i))
        OP_READ:   start_run = (len_q != '0);
        OP_INSERT: start_run = (len_q != LW'(DEPTH)) && (position_i < len_ext);
        OP_DELETE: start_run = (len_q != '0) && (position_i < len_ext)
                               && (position_i != len_ext - LEN_W'(1));
        default:   start_run = 1'b0;
      endcase
    end
  end

  assign to_idle = (mode_q != M_UP);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_run) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (run_done) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = to_idle ? S_IDLE : S_FINAL;
      end
      S_FINAL: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mode_d      = mode_q;
    len_d       = len_q;
    cursor_d    = cursor_q;
    pos_d       = pos_q;
    val_d       = val_q;
    rd_vld_d    = 1'b0;
    rd_addr_d   = rd_addr_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = pos_a;
    ram_wdata_o = value_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = cursor_q;
    out_vld_d   = 1'b0;
    out_st_d    = ST_OK;
    out_elem_d  = '0;
    out_epos_d  = '0;
    out_last_d  = 1'b1;
    out_len_d   = out_len_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          pos_d = pos_a;
          val_d = value_i;
          case (op_e'(operation_i))
            OP_CLEAR: begin
              len_d     = '0;
              out_vld_d = 1'b1;
            end
            OP_READ: begin
              if (len_q == '0) begin
                out_vld_d = 1'b1;
                out_st_d  = ST_EMPTY;
              end else begin
                mode_d   = M_READ;
                cursor_d = '0;
              end
            end
            OP_INSERT: begin
              if (len_q == LW'(DEPTH)) begin
                out_vld_d = 1'b1;
                out_st_d  = ST_FULL;
              end else if (position_i > len_ext) begin
                out_vld_d = 1'b1;
                out_st_d  = ST_BADPOS;
              end else if (position_i == len_ext) begin
                ram_we_o  = 1'b1;
                len_d     = len_q + LW'(1);
                out_vld_d = 1'b1;
              end else begin
                mode_d   = M_UP;
                cursor_d = last_idx;
              end
            end
            OP_UPDATE: begin
              if (len_q == '0) begin
                out_vld_d = 1'b1;
                out_st_d  = ST_EMPTY;
              end else if (position_i >= len_ext) begin
                out_vld_d = 1'b1;
                out_st_d  = ST_BADPOS;
              end else begin
                ram_we_o  = 1'b1;
                out_vld_d = 1'b1;
              end
            end
            OP_DELETE: begin
              if (len_q == '0) begin
                out_vld_d = 1'b1;
                out_st_d  = ST_EMPTY;
              end else if (position_i >= len_ext) begin
                out_vld_d = 1'b1;
                out_st_d  = ST_BADPOS;
              end else if (position_i == len_ext - LEN_W'(1)) begin
                len_d     = len_q - LW'(1);
                out_vld_d = 1'b1;
              end else begin
                mode_d   = M_DN;
                cursor_d = pos_a + AW'(1);
              end
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        ram_re_o  = 1'b1;
        rd_vld_d  = 1'b1;
        rd_addr_d = cursor_q;
        if (!run_done) begin
          cursor_d = (mode_q == M_UP) ? cursor_q - AW'(1) : cursor_q + AW'(1);
        end
      end
      S_DRAIN: begin
        if (mode_q == M_DN) begin
          len_d     = len_q - LW'(1);
          out_vld_d = 1'b1;
        end
      end
      S_FINAL: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = pos_q;
        ram_wdata_o = val_q;
        len_d       = len_q + LW'(1);
        out_vld_d   = 1'b1;
      end
      default: ;
    endcase

    // retire the read issued in the previous cycle
    if ((state_q == S_RUN || state_q == S_DRAIN) && rd_vld_q) begin
      case (mode_q)
        M_UP: begin
          ram_we_o    = 1'b1;
          ram_waddr_o = rd_addr_q + AW'(1);
          ram_wdata_o = ram_rdata_i;
        end
        M_DN: begin
          ram_we_o    = 1'b1;
          ram_waddr_o = rd_addr_q - AW'(1);
          ram_wdata_o = ram_rdata_i;
        end
        M_READ: begin
          out_vld_d  = 1'b1;
          out_elem_d = ram_rdata_i;
          out_epos_d = EPOS_W'(rd_addr_q);
          out_last_d = (rd_addr_q == last_idx);
        end
        default: ;
      endcase
    end

    if (out_vld_d) begin
      out_len_d = LEN_W'(len_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      mode_q    <= M_READ;
      len_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      len_q     <= len_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cursor_q   <= cursor_d;
    pos_q      <= pos_d;
    val_q      <= val_d;
    rd_addr_q  <= rd_addr_d;
    out_st_q   <= out_st_d;
    out_elem_q <= out_elem_d;
    out_epos_q <= out_epos_d;
    out_len_q  <= out_len_d;
    out_last_q <= out_last_d;
  end

  assign valid_o            = out_vld_q;
  assign status_o           = out_st_q;
  assign element_o          = out_elem_q;
  assign element_position_o = out_epos_q;
  assign length_now_o       = out_len_q;
  assign last_o             = out_last_q;

endmodule
